/* sv/multiwave_lfo_generator_unit_assert.svh */
// Assertion macros for the multiwave LFO generator checker.
`ifndef MULTIWAVE_LFO_GENERATOR_UNIT_ASSERT_SVH
`define MULTIWAVE_LFO_GENERATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MLFO_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mlfo assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MLFO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mlfo assertion failed");

`endif

/* sv/mlfo_pkg.sv */
// Types, constants and the sine table builder of the multiwave LFO generator.
package mlfo_pkg;

    localparam int SR_W       = 18;
    localparam int RATE_W     = 16;
    localparam int DEPTH_W    = 16;
    localparam int SAMPLE_W   = 16;
    localparam int SINE_DEPTH = 256;
    localparam int SINE_IDX_W = 8;
    localparam int SINE_VAL_W = 16;

    localparam logic [SR_W-1:0] SR_RESET = 18'd48000;
    localparam longint Q15_ONE = 32768;
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_TRI    = 2'd1,
        WAVE_SQUARE = 2'd2,
        WAVE_SAW    = 2'd3
    } t_wave;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ACC,
        ST_WAVE,
        ST_ROUND
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic acc;
        logic wave;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
    } t_dp_status;

    typedef logic [SINE_VAL_W-1:0] t_sine_rom [SINE_DEPTH+1];

    // Quarter-wave sine table in Q15, built from a Q30 Taylor series at elaboration.
    function automatic t_sine_rom mlfo_sine_rom();
        t_sine_rom rom;
        longint unsigned x;
        longint unsigned term;
        longint sum;
        longint v;
        for (int i = 0; i <= SINE_DEPTH; i++) begin
            x = (PI_HALF_Q30 * 64'(i)) / SINE_DEPTH;
            term = x;
            sum = longint'(x);
            for (int k = 1; k <= 7; k++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * k) * (2 * k + 1));
                if (k[0]) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (sum + 16384) / 32768;
            if (v > Q15_ONE) begin
                v = Q15_ONE;
            end
            rom[i] = SINE_VAL_W'(v);
        end
        return rom;
    endfunction

endpackage

/* sv/multiwave_lfo_generator_unit.sv */
// Multiwave LFO generator: phase-accumulator oscillator with sine, triangle,
// square and sawtooth outputs scaled by a per-tick depth.
// Input channel (i_valid / o_stall): one request per sample tick with
// i_wave_select, i_rate (Q8.8 Hz) and i_depth (Q1.15). o_stall is high while
// a request is being worked on.
// Output channel (o_valid / i_stall): one signed Q1.15 o_sample per request.
// Configuration (i_cfg_valid / o_cfg_ready): i_cfg_data sets the sample rate
// in hertz; write it only while no request is in flight.
// A request passes through the divide, phase update, waveform and rounding
// steps; the rounding step loads the result into the output register and
// raises o_valid, and o_stall falls with it. The restoring divider that turns
// rate over sample rate into the phase increment takes most of that time,
// at one quotient bit per cycle over PHASE_BITS+8 bits.
// The result sits in an output register; while the receiver stalls, a new
// request may still be taken and runs up to the rounding step, where it
// waits until the output register is free.
// Reset clears the phase and sets the sample rate to 48000.
module multiwave_lfo_generator_unit
    import mlfo_pkg::*;
#(
    parameter int PHASE_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_wave_select,
    input  logic [RATE_W-1:0]   i_rate,
    input  logic [DEPTH_W-1:0]  i_depth,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [SAMPLE_W-1:0] o_sample,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [SR_W-1:0]     i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    mlfo_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_cmd    (cmd),
        .i_status (status)
    );

    mlfo_datapath #(
        .PHASE_BITS (PHASE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_wave_select (i_wave_select),
        .i_rate        (i_rate),
        .i_depth       (i_depth),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_sample      (o_sample)
    );

endmodule

/* sv/mlfo_ctrl.sv */
// Controller state machine: sequences the divide, phase update, waveform and rounding steps.
module mlfo_ctrl
    import mlfo_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                n_state = ST_WAVE;
            end
            ST_WAVE: begin
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE:  o_cmd.load     = i_valid;
            ST_DIV:   o_cmd.div_step = 1'b1;
            ST_ACC:   o_cmd.acc      = 1'b1;
            ST_WAVE:  o_cmd.wave     = 1'b1;
            ST_ROUND: o_cmd.load_out = out_free;
            default:  o_cmd = '0;
        endcase
    end

    // The output register stays full until taken; a new result may load in the same cycle that the old one is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* sv/mlfo_datapath.sv */
// Datapath: restoring divider, phase accumulator, waveform shaping, depth scaling and rounding.
module mlfo_datapath
    import mlfo_pkg::*;
#(
    parameter int PHASE_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    input  logic [1:0]          i_wave_select,
    input  logic [RATE_W-1:0]   i_rate,
    input  logic [DEPTH_W-1:0]  i_depth,
    input  logic                i_cfg_we,
    input  logic [SR_W-1:0]     i_cfg_data,
    output logic [SAMPLE_W-1:0] o_sample
);

    localparam int DIV_W = PHASE_BITS + 8;
    localparam int CNT_W = $clog2(DIV_W);
    localparam t_sine_rom SINE_ROM = mlfo_sine_rom();

    logic [SR_W-1:0]       r_sr;
    logic [PHASE_BITS-1:0] r_phase;
    logic [DIV_W-1:0]      r_quo;
    logic [SR_W:0]         r_rem;
    logic [CNT_W-1:0]      r_cnt;
    t_wave                 r_sel;
    logic [DEPTH_W-1:0]    r_depth;
    logic [31:0]           r_prod;
    logic                  r_neg;
    logic [SAMPLE_W-1:0]   r_sample;

    logic [SR_W:0]         rem_shift;
    logic [SR_W+1:0]       rem_diff;
    logic                  rem_ge;

    logic [15:0]           q;
    logic [1:0]            quadrant;
    logic [SINE_IDX_W-1:0] idx;
    logic [SINE_IDX_W:0]   rom_addr;
    logic [16:0]           tri_full;
    logic [15:0]           w_mag;
    logic                  w_neg;

    logic [32:0]           round_sum;
    logic [17:0]           mag_r;
    logic [SAMPLE_W-1:0]   n_sample;

    // One quotient bit per step; the dividend shifts out as the quotient shifts in.
    assign rem_shift = {r_rem[SR_W-1:0], r_quo[DIV_W-1]};
    assign rem_diff  = {1'b0, rem_shift} - {2'b00, r_sr};
    assign rem_ge    = !rem_diff[SR_W+1];

    assign o_status.div_last = (r_cnt == '0);

    assign q        = r_phase[PHASE_BITS-1 -: 16];
    assign quadrant = r_phase[PHASE_BITS-1 -: 2];
    assign idx      = r_phase[PHASE_BITS-3 -: SINE_IDX_W];
    assign rom_addr = quadrant[0] ? ((SINE_IDX_W+1)'(SINE_DEPTH) - {1'b0, idx}) : {1'b0, idx};
    assign tri_full = q[15] ? (17'h10000 - {1'b0, q}) : {1'b0, q};

    always_comb begin
        w_mag = '0;
        w_neg = 1'b0;
        case (r_sel)
            WAVE_SINE: begin
                w_mag = SINE_ROM[rom_addr];
                w_neg = quadrant[1];
            end
            WAVE_TRI: begin
                w_mag = tri_full[15:0];
            end
            WAVE_SQUARE: begin
                w_mag = 16'h8000;
                w_neg = r_phase[PHASE_BITS-1];
            end
            WAVE_SAW: begin
                if (q > 16'h8000) begin
                    w_mag = q - 16'h8000;
                    w_neg = 1'b1;
                end else begin
                    w_mag = 16'h8000 - q;
                end
            end
            default: begin
                w_mag = '0;
            end
        endcase
    end

    // Round half away from zero, then saturate to the signed 16-bit range.
    assign round_sum = {1'b0, r_prod} + 33'd16384;
    assign mag_r     = round_sum[32:15];

    always_comb begin
        if (r_neg) begin
            if (mag_r > 18'd32768) begin
                n_sample = 16'h8000;
            end else begin
                n_sample = ~mag_r[15:0] + 16'd1;
            end
        end else begin
            if (mag_r > 18'd32767) begin
                n_sample = 16'h7FFF;
            end else begin
                n_sample = mag_r[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr    <= SR_RESET;
            r_phase <= '0;
        end else begin
            if (i_cfg_we) begin
                r_sr <= i_cfg_data;
            end
            // A zero sample rate leaves the phase where it is.
            if (i_cmd.acc && (r_sr != '0)) begin
                r_phase <= r_phase + r_quo[PHASE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo   <= {i_rate, {(PHASE_BITS-8){1'b0}}};
            r_rem   <= '0;
            r_cnt   <= CNT_W'(DIV_W - 1);
            r_sel   <= t_wave'(i_wave_select);
            r_depth <= i_depth;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[DIV_W-2:0], rem_ge};
            r_rem <= rem_ge ? rem_diff[SR_W:0] : rem_shift;
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.wave) begin
            r_prod <= w_mag * r_depth;
            r_neg  <= w_neg;
        end
        if (i_cmd.load_out) begin
            r_sample <= n_sample;
        end
    end

    assign o_sample = r_sample;

endmodule

/* sv/mlfo_checker.sv */
// Port-level checker for the multiwave LFO generator, bound to the top level.
`include "multiwave_lfo_generator_unit_assert.svh"

module mlfo_checker
    import mlfo_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [SAMPLE_W-1:0] o_sample
);

    logic in_accept;

    assign in_accept = i_valid && !o_stall;

    // One request at a time: the block is busy right after taking one.
    `MLFO_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_accept, o_stall)

    // A result never appears in the cycle right after its request was taken.
    `MLFO_ASSERT_NEXT(a_no_early_result, i_clk, i_rst_n, in_accept, !$rose(o_valid))

    // When a result is delivered, the block is ready for the next request.
    `MLFO_ASSERT_SAME(a_ready_with_result, i_clk, i_rst_n, $rose(o_valid), !o_stall)

    // A stalled result stays put.
    `MLFO_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, o_valid && i_stall,
                      o_valid && $stable(o_sample))

endmodule

bind multiwave_lfo_generator_unit mlfo_checker u_mlfo_checker (.*);

/* tb/tb_multiwave_lfo_generator_unit.sv */
// Self-checking testbench for the multiwave LFO generator unit.
module tb_multiwave_lfo_generator_unit;
    import mlfo_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUARTER_DEPTH = 256;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [1:0]          i_wave_select = '0;
    logic [RATE_W-1:0]   i_rate = '0;
    logic [DEPTH_W-1:0]  i_depth = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [SAMPLE_W-1:0] o_sample;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [SR_W-1:0]     i_cfg_data = '0;

    // Predictor state: phase accumulator, sample rate and quarter-wave sine table.
    logic [23:0]         lfo_phase;
    logic [SR_W-1:0]     lfo_sample_rate;
    longint              quarter_sine_q15 [QUARTER_DEPTH+1];

    logic [SAMPLE_W-1:0] expected_samples [$];
    int                  samples_checked = 0;
    int                  mismatch_count = 0;
    int                  rate_writes = 0;
    int                  cycle_count = 0;
    int                  gap_pct = 0;
    int                  stall_pct = 0;
    int                  stall_left = 0;

    multiwave_lfo_generator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_wave_select (i_wave_select),
        .i_rate        (i_rate),
        .i_depth       (i_depth),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sample      (o_sample),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d samples outstanding", $time,
                     expected_samples.size());
            $display("tb_multiwave_lfo_generator_unit: errors");
            $finish;
        end
    end

    // Receiver back-pressure comes in bursts so that stalls cover whole requests.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_left <= $urandom_range(1, 30);
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge i_clk) begin
        logic [SAMPLE_W-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected sample, expected none, actual %0d", $time,
                         $signed(o_sample));
                mismatch_count++;
            end else begin
                want = expected_samples.pop_front();
                samples_checked++;
                if (o_sample !== want) begin
                    $display("%0t: sample mismatch, expected %0d, actual %0d", $time,
                             $signed(want), $signed(o_sample));
                    mismatch_count++;
                end
            end
        end
    end

    // Q30 Taylor series of sin over a quarter turn, rounded to Q15.
    function automatic void build_quarter_sine();
        longint unsigned x;
        longint unsigned term;
        longint sum;
        longint v;
        for (int i = 0; i <= QUARTER_DEPTH; i++) begin
            x = (64'd1686629713 * 64'(i)) / 64'(QUARTER_DEPTH);
            term = x;
            sum = longint'(x);
            for (int k = 1; k <= 7; k++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * k) * (2 * k + 1));
                sum = (k % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (sum + 16384) / 32768;
            quarter_sine_q15[i] = (v > 32768) ? 32768 : v;
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] next_lfo_sample(t_wave wave,
                                                            logic [RATE_W-1:0] rate,
                                                            logic [DEPTH_W-1:0] depth);
        longint unsigned step;
        longint unsigned mag;
        longint wv;
        longint r;
        longint q;
        int idx;
        step = 0;
        if (lfo_sample_rate != 0) begin
            step = (64'(rate) << 24) / (64'(lfo_sample_rate) << 8);
        end
        lfo_phase = 24'(64'(lfo_phase) + step);
        q = longint'(lfo_phase[23:8]);
        idx = int'(lfo_phase[21:14]);
        case (wave)
            WAVE_SINE: begin
                case (lfo_phase[23:22])
                    2'd0: wv = quarter_sine_q15[idx];
                    2'd1: wv = quarter_sine_q15[QUARTER_DEPTH - idx];
                    2'd2: wv = -quarter_sine_q15[idx];
                    default: wv = -quarter_sine_q15[QUARTER_DEPTH - idx];
                endcase
            end
            WAVE_TRI: wv = 32768 - ((q >= 32768) ? q - 32768 : 32768 - q);
            WAVE_SQUARE: wv = lfo_phase[23] ? -32768 : 32768;
            default: wv = 32768 - q;
        endcase
        mag = 64'((wv < 0) ? -wv : wv) * 64'(depth);
        mag = (mag + 16384) >> 15;
        r = (wv < 0) ? -longint'(mag) : longint'(mag);
        if (r > 32767) begin
            r = 32767;
        end
        if (r < -32768) begin
            r = -32768;
        end
        return SAMPLE_W'(r);
    endfunction

    task automatic send_tick(t_wave wave, logic [RATE_W-1:0] rate,
                             logic [DEPTH_W-1:0] depth);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 30);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_wave_select <= wave;
        i_rate <= rate;
        i_depth <= depth;
        do @(posedge i_clk); while (o_stall);
        expected_samples.push_back(next_lfo_sample(wave, rate, depth));
    endtask

    // Lowers the request line and waits until every sample has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_sample_rate(logic [SR_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        lfo_sample_rate = value;
        rate_writes++;
    endtask

    // With rate zero the phase stays at zero; full-scale values must saturate.
    task automatic test_reset_rate();
        send_tick(WAVE_SINE, 16'd0, 16'd32768);
        send_tick(WAVE_TRI, 16'd0, 16'd65535);
        send_tick(WAVE_SQUARE, 16'd0, 16'd32768);
        send_tick(WAVE_SQUARE, 16'd0, 16'd65535);
        send_tick(WAVE_SAW, 16'd0, 16'd32768);
        send_tick(WAVE_SAW, 16'd0, 16'd0);
        wait_drained();
    endtask

    // Just over a quarter of a turn per tick walks the sine through every quadrant.
    task automatic test_sine_quadrants();
        write_sample_rate(18'd1000);
        for (int i = 0; i < 6; i++) begin
            send_tick(WAVE_SINE, 16'hFFFF, (i % 2 == 0) ? 16'd32768 : 16'd20000);
        end
        wait_drained();
    endtask

    // Huge increments wrap the phase; a zero sample rate freezes it.
    task automatic test_wrap_and_hold();
        write_sample_rate(18'd1);
        send_tick(WAVE_SINE, 16'hFFFF, 16'd32768);
        send_tick(WAVE_TRI, 16'hFFFF, 16'd32768);
        send_tick(WAVE_SQUARE, 16'hFFFF, 16'd40000);
        send_tick(WAVE_SAW, 16'hFFFF, 16'hFFFF);
        write_sample_rate(18'd0);
        send_tick(WAVE_SAW, 16'hFFFF, 16'd32768);
        send_tick(WAVE_TRI, 16'h5555, 16'hAAAA);
        send_tick(WAVE_SINE, 16'hAAAA, 16'h5555);
        write_sample_rate(18'h3FFFF);
        send_tick(WAVE_SAW, 16'hFFFF, 16'hFFFF);
        send_tick(WAVE_SQUARE, 16'hFFFF, 16'd1);
        wait_drained();
    endtask

    task automatic test_random_traffic(logic [SR_W-1:0] rate_hz, int send_gap_pct,
                                       int recv_stall_pct, int count);
        logic [RATE_W-1:0] rate;
        logic [DEPTH_W-1:0] depth;
        write_sample_rate(rate_hz);
        gap_pct = send_gap_pct;
        stall_pct = recv_stall_pct;
        for (int i = 0; i < count; i++) begin
            rate = ($urandom_range(0, 3) == 0) ? RATE_W'($urandom_range(0, 255))
                                               : RATE_W'($urandom_range(0, 65535));
            depth = ($urandom_range(0, 3) == 0) ? DEPTH_W'($urandom_range(0, 65535))
                                                : DEPTH_W'($urandom_range(0, 32768));
            send_tick(t_wave'($urandom_range(0, 3)), rate, depth);
        end
        wait_drained();
        gap_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        build_quarter_sine();
        lfo_phase = '0;
        lfo_sample_rate = SR_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_rate();
        test_sine_quadrants();
        test_wrap_and_hold();
        test_random_traffic(18'd48000, 0, 0, 125);
        test_random_traffic(18'd1000, 67, 0, 125);
        test_random_traffic(18'd192000, 0, 67, 125);
        test_random_traffic(SR_W'($urandom_range(1, 262143)), 17, 17, 125);
        $display("checked %0d samples over all four waveforms and %0d sample rate settings,",
                 samples_checked, rate_writes);
        $display("with sender gaps and receiver stalls in separate and combined phases");
        if (mismatch_count == 0) begin
            $display("tb_multiwave_lfo_generator_unit: clean");
        end else begin
            $display("tb_multiwave_lfo_generator_unit: errors");
        end
        $finish;
    end

endmodule
